@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros used by the checker module of the core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds at every clock edge outside reset.
`define OALE_ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ordered list engine check failed");

// Property whose consequent must hold in the cycle after the antecedent.
`define OALE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ordered list engine check failed");

`endif

@@ rtl/core/oale_pkg.sv @@
// ----------------------------------------------------------------------------
// oale_pkg
// Field widths, operation and status codes, and the command and status
// bundles that join the list engine's controller and datapath.
// ----------------------------------------------------------------------------
package oale_pkg;

  localparam int FUNC_W      = 3;
  localparam int POS_W       = 6;
  localparam int VALUE_W     = 32;
  localparam int STATUS_W    = 3;
  localparam int COUNT_W     = 7;
  localparam int CFG_W       = 7;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  localparam logic [CFG_W-1:0] CAP_RESET = 7'd64;

  // Operation codes carried in the input word's tuser.
  localparam logic [FUNC_W-1:0] FN_APPEND = 3'd0;
  localparam logic [FUNC_W-1:0] FN_INSERT = 3'd1;
  localparam logic [FUNC_W-1:0] FN_EDIT   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_DELETE = 3'd3;
  localparam logic [FUNC_W-1:0] FN_READ   = 3'd4;
  localparam logic [FUNC_W-1:0] FN_FIND   = 3'd5;

  // Result status codes carried in the output word's tuser.
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

  // One datapath action per cycle.
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_APPEND,
    ACT_EDIT,
    ACT_UP_INIT,
    ACT_DN_INIT,
    ACT_FIND_INIT,
    ACT_RD_POS,
    ACT_STEP,
    ACT_INS_FIN,
    ACT_DEL_FIN
  } act_t;

  // Source of the result data word when the status is ok.
  typedef enum logic [1:0] {
    DSEL_ZERO,
    DSEL_RDATA,
    DSEL_INDEX
  } dsel_t;

  typedef struct packed {
    logic                load_req;
    act_t                act;
    logic                res_set;
    logic [STATUS_W-1:0] res_status;
    dsel_t               res_dsel;
    logic                out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              full;
    logic              empty;
    logic              pos_le_cnt;
    logic              pos_lt_cnt;
    logic              more;
    logic              pend;
    logic              key_hit;
    logic              out_free;
  } dp_stat_t;

endpackage

@@ rtl/core/oale_ctrl.sv @@
// ----------------------------------------------------------------------------
// oale_ctrl
// Controller of the list engine: decodes each request, checks it against
// the list state and sequences the datapath through shifts and searches.
// ----------------------------------------------------------------------------
module oale_ctrl
  import oale_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_FIND,
    S_READ,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    cmd.load_req   = 1'b0;
    cmd.act        = ACT_NONE;
    cmd.res_set    = 1'b0;
    cmd.res_status = ST_OK;
    cmd.res_dsel   = DSEL_ZERO;
    cmd.out_load   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.res_set = 1'b1;
        state_nxt   = S_DONE;
        case (stat.func)
          FN_APPEND: begin
            if (stat.full) cmd.res_status = ST_FULL;
            else cmd.act = ACT_APPEND;
          end
          FN_INSERT: begin
            if (stat.full) begin
              cmd.res_status = ST_FULL;
            end else if (!stat.pos_le_cnt) begin
              cmd.res_status = ST_BADPOS;
            end else begin
              cmd.act   = ACT_UP_INIT;
              state_nxt = S_SHIFT_UP;
            end
          end
          FN_EDIT: begin
            if (stat.pos_lt_cnt) cmd.act = ACT_EDIT;
            else cmd.res_status = ST_BADPOS;
          end
          FN_DELETE: begin
            if (stat.empty) begin
              cmd.res_status = ST_EMPTY;
            end else if (!stat.pos_lt_cnt) begin
              cmd.res_status = ST_BADPOS;
            end else begin
              cmd.act   = ACT_DN_INIT;
              state_nxt = S_SHIFT_DN;
            end
          end
          FN_READ: begin
            if (stat.pos_lt_cnt) begin
              cmd.act   = ACT_RD_POS;
              state_nxt = S_READ;
            end else begin
              cmd.res_status = ST_BADPOS;
            end
          end
          FN_FIND: begin
            cmd.act   = ACT_FIND_INIT;
            state_nxt = S_FIND;
          end
          default: begin
            cmd.res_status = ST_BADPOS;
          end
        endcase
      end
      S_SHIFT_UP: begin
        if (stat.more || stat.pend) begin
          cmd.act = ACT_STEP;
        end else begin
          cmd.act   = ACT_INS_FIN;
          state_nxt = S_DONE;
        end
      end
      S_SHIFT_DN: begin
        if (stat.more || stat.pend) begin
          cmd.act = ACT_STEP;
        end else begin
          cmd.act   = ACT_DEL_FIN;
          state_nxt = S_DONE;
        end
      end
      S_FIND: begin
        cmd.act = ACT_STEP;
        if (stat.pend && stat.key_hit) begin
          cmd.res_set  = 1'b1;
          cmd.res_dsel = DSEL_INDEX;
          state_nxt    = S_DONE;
        end else if (!stat.more && !stat.pend) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_NOTFOUND;
          state_nxt      = S_DONE;
        end
      end
      S_READ: begin
        cmd.res_set  = 1'b1;
        cmd.res_dsel = DSEL_RDATA;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/oale_dp.sv @@
// ----------------------------------------------------------------------------
// oale_dp
// Datapath of the list engine: entry memory with one write and one
// registered read port, fill count, capacity register, sweep pointers and
// the result and output registers.
// ----------------------------------------------------------------------------
module oale_dp
  import oale_pkg::*;
#(
  parameter int DEPTH  = 64,
  parameter int DATA_W = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wen,
  input  logic [CFG_W-1:0]           cfg_wdata,
  input  logic [FUNC_W-1:0]          in_func,
  input  logic [POS_W-1:0]           in_position,
  input  logic signed [VALUE_W-1:0]  in_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [STATUS_W-1:0]        out_status,
  output logic signed [VALUE_W-1:0]  out_data,
  output logic [COUNT_W-1:0]         out_count,
  output logic                       out_empty,
  output logic                       out_full,
  input  dp_cmd_t                    cmd,
  output dp_stat_t                   stat
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int PW    = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  logic [CNT_W-1:0]    fill_count_r, fill_count_nxt;
  logic [CFG_W-1:0]    cap_r;
  logic [FUNC_W-1:0]   func_r;
  logic [POS_W-1:0]    pos_r;
  logic [DATA_W-1:0]   value_r;
  logic [CNT_W-1:0]    idx_r, idx_nxt, idx_inc;
  logic [AW-1:0]       wa_r, wa_nxt;
  logic                pend_r, pend_nxt;
  logic [STATUS_W-1:0] res_status_r;
  logic [VALUE_W-1:0]  res_data_r, res_data_nxt;
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [VALUE_W-1:0]  out_data_r;
  logic [COUNT_W-1:0]  out_count_r;
  logic                out_empty_r, out_full_r;

  logic [CW-1:0]     cap_ext, eff_cap;
  logic              full, more;
  logic              we, re;
  logic [AW-1:0]     waddr, raddr, src_addr;
  logic [DATA_W-1:0] wdata;

  // Capacity register: zero acts as one, anything past the depth as the depth.
  assign cap_ext = CW'(cap_r);
  assign eff_cap = (cap_r == '0) ? CW'(1) :
                   ((cap_ext > CW'(DEPTH)) ? CW'(DEPTH) : cap_ext);
  assign full    = (CW'(fill_count_r) >= eff_cap);
  assign idx_inc = idx_r + CNT_W'(1);

  // Whether the running sweep still has an entry to read, and where it reads from.
  always_comb begin
    case (func_r)
      FN_INSERT: begin
        more     = (PW'(idx_r) > PW'(pos_r));
        src_addr = AW'(idx_r - CNT_W'(1));
      end
      FN_DELETE: begin
        more     = (idx_inc < fill_count_r);
        src_addr = AW'(idx_inc);
      end
      default: begin
        more     = (idx_r < fill_count_r);
        src_addr = AW'(idx_r);
      end
    endcase
  end

  assign stat.func       = func_r;
  assign stat.full       = full;
  assign stat.empty      = (fill_count_r == '0);
  assign stat.pos_le_cnt = (PW'(pos_r) <= PW'(fill_count_r));
  assign stat.pos_lt_cnt = (PW'(pos_r) < PW'(fill_count_r));
  assign stat.more       = more;
  assign stat.pend       = pend_r;
  assign stat.key_hit    = (rd_data_r == value_r);
  assign stat.out_free   = !out_valid_r || out_ready;

  always_comb begin
    we             = 1'b0;
    waddr          = AW'(pos_r);
    wdata          = value_r;
    re             = 1'b0;
    raddr          = src_addr;
    idx_nxt        = idx_r;
    wa_nxt         = wa_r;
    pend_nxt       = 1'b0;
    fill_count_nxt = fill_count_r;
    case (cmd.act)
      ACT_APPEND: begin
        we             = 1'b1;
        waddr          = AW'(fill_count_r);
        fill_count_nxt = fill_count_r + CNT_W'(1);
      end
      ACT_EDIT: begin
        we = 1'b1;
      end
      ACT_UP_INIT: begin
        idx_nxt = fill_count_r;
      end
      ACT_DN_INIT: begin
        idx_nxt = CNT_W'(pos_r);
      end
      ACT_FIND_INIT: begin
        idx_nxt = '0;
      end
      ACT_RD_POS: begin
        re       = 1'b1;
        raddr    = AW'(pos_r);
        pend_nxt = 1'b1;
      end
      ACT_STEP: begin
        // Write back the word read last cycle, one place up or down.
        if (pend_r && (func_r != FN_FIND)) begin
          we    = 1'b1;
          waddr = wa_r;
          wdata = rd_data_r;
        end
        if (more) begin
          re       = 1'b1;
          pend_nxt = 1'b1;
          wa_nxt   = AW'(idx_r);
          idx_nxt  = (func_r == FN_INSERT) ? (idx_r - CNT_W'(1)) : idx_inc;
        end
      end
      ACT_INS_FIN: begin
        we             = 1'b1;
        fill_count_nxt = fill_count_r + CNT_W'(1);
      end
      ACT_DEL_FIN: begin
        fill_count_nxt = fill_count_r - CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    case (cmd.res_dsel)
      DSEL_RDATA: res_data_nxt = VALUE_W'(rd_data_r);
      DSEL_INDEX: res_data_nxt = VALUE_W'(wa_r);
      default:    res_data_nxt = '0;
    endcase
    if (cmd.res_status != ST_OK) res_data_nxt = '1;
  end

  // Entry memory; contents are undefined until written.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rd_data_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_count_r <= '0;
      cap_r        <= CAP_RESET;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      fill_count_r <= fill_count_nxt;
      pend_r       <= pend_nxt;
      if (cfg_wen) cap_r <= cfg_wdata;
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    wa_r  <= wa_nxt;
    if (cmd.load_req) begin
      func_r  <= in_func;
      pos_r   <= in_position;
      value_r <= DATA_W'(in_value);
    end
    if (cmd.res_set) begin
      res_status_r <= cmd.res_status;
      res_data_r   <= res_data_nxt;
    end
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_data_r   <= res_data_r;
      out_count_r  <= COUNT_W'(fill_count_r);
      out_empty_r  <= (fill_count_r == '0);
      out_full_r   <= full;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_data   = out_data_r;
  assign out_count  = out_count_r;
  assign out_empty  = out_empty_r;
  assign out_full   = out_full_r;

endmodule

@@ rtl/core/ordered_array_list_engine_top.sv @@
// Flow: append, edit and refused requests pass from accept through execute to the result;
// read adds a registered memory read. Insert and delete move one entry a cycle through the
// single write port, and find compares the entries in order until a hit or the end of the
// list; an empty list gives not found without a read.
// Throughput: one request at a time; the next word is accepted once the result is registered.
// Reset: count cleared, capacity set to 64; the entry memory is not cleared, no clearing pass.
// ----------------------------------------------------------------------------
// ordered_array_list_engine_top
// Bounded ordered list of signed words with append, insert, edit, delete,
// read and find requests, each answered by one status word.
// ----------------------------------------------------------------------------
module ordered_array_list_engine_top
  import oale_pkg::*;
#(
  parameter int DEPTH  = 64,
  parameter int DATA_W = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Capacity register write port.
  input  logic                   cfg_wen,
  input  logic [CFG_W-1:0]       cfg_wdata,
  // Request stream.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // position[5:0], value[37:6], zero fill
  input  logic [FUNC_W-1:0]      in_tuser,   // func[2:0]
  // Result stream.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // data[31:0], entry_count[38:32],
                                             // is_empty[39], is_full[40], zero fill
  output logic [STATUS_W-1:0]    out_tuser   // status[2:0]
);

  // The controller walks each request through the datapath; the datapath owns
  // every stored element but the controller state, including the output register,
  // so a result can wait at the output while the next request word is already accepted.
  dp_cmd_t  cmd;
  dp_stat_t stat;

  logic                       ctrl_ready;
  logic signed [VALUE_W-1:0]  res_data;
  logic [COUNT_W-1:0]         res_count;
  logic                       res_empty, res_full;

  oale_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (ctrl_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  oale_dp #(
    .DEPTH  (DEPTH),
    .DATA_W (DATA_W)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wen     (cfg_wen),
    .cfg_wdata   (cfg_wdata),
    .in_func     (in_tuser),
    .in_position (in_tdata[POS_W-1:0]),
    .in_value    (in_tdata[POS_W+VALUE_W-1:POS_W]),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_status  (out_tuser),
    .out_data    (res_data),
    .out_count   (res_count),
    .out_empty   (res_empty),
    .out_full    (res_full),
    .cmd         (cmd),
    .stat        (stat)
  );

  assign in_tready = ctrl_ready;

  // The result word packs its fields from the low bit up, zero filled to bytes.
  assign out_tdata = {(OUT_TDATA_W - VALUE_W - COUNT_W - 2)'(0),
                      res_full, res_empty, res_count, res_data};

endmodule

@@ rtl/core/oale_checker.sv @@
// ----------------------------------------------------------------------------
// oale_checker
// Port-level checks on the list engine's result stream, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module oale_checker
  import oale_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [STATUS_W-1:0]    out_tuser
);

  // A stalled result word stays put until it is taken.
  `OALE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // Every failed request reports minus one as its data.
  `OALE_ASSERT_ALWAYS(a_fail_data, clk, rst_n, (out_tvalid && (out_tuser != ST_OK)) |-> (out_tdata[31:0] == 32'hFFFF_FFFF))

  // The empty flag agrees with the reported count.
  `OALE_ASSERT_ALWAYS(a_empty_flag, clk, rst_n, out_tvalid |-> (out_tdata[39] == (out_tdata[38:32] == 7'd0)))

  // A request refused for lack of room leaves the list full.
  `OALE_ASSERT_ALWAYS(a_full_refusal, clk, rst_n, (out_tvalid && (out_tuser == ST_FULL)) |-> out_tdata[40])

endmodule

bind ordered_array_list_engine_top oale_checker u_oale_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

@@ test/oale_result_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// oale_result_checker
// Watches the request, result and capacity ports of the ordered list engine.
// It keeps its own copy of the list, predicts the result word of each
// accepted request and compares every accepted result with the oldest
// prediction.
// ----------------------------------------------------------------------------
module oale_result_checker
  import oale_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wen,
  input  logic [CFG_W-1:0]       cfg_wdata,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [FUNC_W-1:0]      in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic [STATUS_W-1:0]    out_tuser,
  output int                     mismatch_count,
  output int                     pending_words
);

  localparam int unsigned LIST_DEPTH = 64;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  data;
    logic [COUNT_W-1:0]  count;
    logic                empty;
    logic                full;
  } list_result_t;

  logic [VALUE_W-1:0] list_words [LIST_DEPTH];
  int unsigned        held_count;
  logic [CFG_W-1:0]   capacity_reg;
  list_result_t       expected_results [$];
  int                 result_index;

  initial begin
    mismatch_count = 0;
    pending_words  = 0;
    result_index   = 0;
  end

  // A register value of zero behaves as one, anything above the depth as the depth.
  function automatic bit list_is_full();
    int unsigned usable;
    usable = 32'(capacity_reg);
    if (usable == 0) usable = 1;
    if (usable > LIST_DEPTH) usable = LIST_DEPTH;
    return held_count >= usable;
  endfunction

  function automatic list_result_t apply_request(input logic [FUNC_W-1:0]  fn,
                                                 input logic [POS_W-1:0]   pos,
                                                 input logic [VALUE_W-1:0] val);
    list_result_t        res;
    logic [STATUS_W-1:0] st;
    logic [VALUE_W-1:0]  word_out;
    int unsigned         idx;
    int unsigned         slot;
    st       = ST_OK;
    word_out = '0;
    slot     = 32'(pos);
    case (fn)
      FN_APPEND: begin
        if (list_is_full()) st = ST_FULL;
        else begin
          list_words[held_count] = val;
          held_count++;
        end
      end
      FN_INSERT: begin
        if (list_is_full()) st = ST_FULL;
        else if (slot > held_count) st = ST_BADPOS;
        else begin
          for (idx = held_count; idx > slot; idx--) list_words[idx] = list_words[idx-1];
          list_words[slot] = val;
          held_count++;
        end
      end
      FN_EDIT: begin
        if (slot < held_count) list_words[slot] = val;
        else st = ST_BADPOS;
      end
      FN_DELETE: begin
        if (held_count == 0) st = ST_EMPTY;
        else if (slot >= held_count) st = ST_BADPOS;
        else begin
          for (idx = slot; idx + 1 < held_count; idx++) list_words[idx] = list_words[idx+1];
          held_count--;
        end
      end
      FN_READ: begin
        if (slot < held_count) word_out = list_words[slot];
        else st = ST_BADPOS;
      end
      FN_FIND: begin
        st = ST_NOTFOUND;
        for (idx = 0; idx < held_count; idx++) begin
          if (st != ST_OK && list_words[idx] == val) begin
            st       = ST_OK;
            word_out = idx;
          end
        end
      end
      default: st = ST_BADPOS;
    endcase
    if (st != ST_OK) word_out = '1;
    res.status = st;
    res.data   = word_out;
    res.count  = held_count[COUNT_W-1:0];
    res.empty  = (held_count == 0);
    res.full   = list_is_full();
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= 60)
      $display("%0t: result %0d: %s is %0h, expected %0h", $time, result_index, what, got,
               want);
  endtask

  always @(posedge clk) begin
    list_result_t got;
    list_result_t want;
    if (!rst_n) begin
      held_count   = 0;
      capacity_reg = CAP_RESET;
      expected_results.delete();
    end else begin
      if (cfg_wen) capacity_reg = cfg_wdata;
      // Results are checked before the request of this edge is predicted, so a
      // result that shows up with nothing outstanding is caught.
      if (out_tvalid && out_tready) begin
        got.status = out_tuser;
        got.data   = out_tdata[31:0];
        got.count  = out_tdata[38:32];
        got.empty  = out_tdata[39];
        got.full   = out_tdata[40];
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result word, status", 32'(got.status), '0);
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
          if (got.data !== want.data) report_mismatch("data", got.data, want.data);
          if (got.count !== want.count)
            report_mismatch("entry_count", 32'(got.count), 32'(want.count));
          if (got.empty !== want.empty)
            report_mismatch("is_empty", 32'(got.empty), 32'(want.empty));
          if (got.full !== want.full)
            report_mismatch("is_full", 32'(got.full), 32'(want.full));
        end
        result_index++;
      end
      if (in_tvalid && in_tready)
        expected_results.push_back(apply_request(in_tuser, in_tdata[5:0], in_tdata[37:6]));
    end
    pending_words <= expected_results.size();
  end

endmodule

@@ test/ordered_array_list_engine_top_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ordered_array_list_engine_top_test
// Drives the ordered list engine with a directed opening and then with long
// random runs of requests under several capacities and idle patterns. A
// separate checker predicts and compares every result word; this module only
// makes stimulus, keeps a watchdog and gives the verdict.
// ----------------------------------------------------------------------------
module ordered_array_list_engine_top_test;
  import oale_pkg::*;

  // Function codes the engine does not implement; both must be refused.
  localparam logic [FUNC_W-1:0] FN_SPARE_LO = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE_HI = 3'd7;

  // Cycles without any accepted word before the run is declared hung. The
  // longest legal quiet stretch is the receiver hold-off plus one find or
  // shift over the whole list, well below this.
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_WORDS    = 185;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   cfg_wen    = 1'b0;
  logic [CFG_W-1:0]       cfg_wdata  = '0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [FUNC_W-1:0]      in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]    out_tuser;

  int mismatch_count;
  int pending_words;

  // Idle chances in percent for each side, changed by the stimulus per phase.
  int send_idle_pct = 24;
  int recv_idle_pct = 56;

  // The stimulus asks for a long receiver hold-off by bumping this counter.
  int hold_requests = 0;

  // Last list state seen on the result channel, used to steer the stimulus:
  // positions are aimed near the count, and the request mix flips between
  // growing and shrinking when the list is seen full or empty.
  logic [COUNT_W-1:0] seen_count = '0;
  logic               growing    = 1'b1;

  always #2 clk = ~clk;

  ordered_array_list_engine_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  oale_result_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wen        (cfg_wen),
    .cfg_wdata      (cfg_wdata),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .mismatch_count (mismatch_count),
    .pending_words  (pending_words)
  );

  always @(posedge clk) begin
    if (out_tvalid && out_tready) begin
      seen_count <= out_tdata[38:32];
      if (out_tdata[40]) begin
        growing <= 1'b0;
      end else if (out_tdata[39]) begin
        growing <= 1'b1;
      end
    end
  end

  // Result side. Each cycle it decides at random whether to take a word. When
  // a hold-off is requested it keeps tready low for a long count of its own
  // while the sender keeps offering, so the engine fills and stalls its input.
  initial begin
    int hold_served;
    hold_served = 0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog: counts cycles in a row with no word moved, reset or cfg write.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wen) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("watchdog expired with %0d result words outstanding", pending_words);
    $display("*** FAILED ***");
    $finish;
  end

  // Offers one request word and returns at the edge where it is taken. The
  // valid is lowered only when a gap is inserted, so back-to-back words never
  // lower and raise it within one time step.
  task automatic send_word(input logic [FUNC_W-1:0] fn, input logic [POS_W-1:0] pos,
                           input logic [VALUE_W-1:0] val);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= fn;
    in_tdata  <= {2'b00, val, pos};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Stops offering and waits until every predicted result has been taken, so
  // the engine is idle before the capacity register is touched.
  task automatic settle_list();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CFG_W-1:0] cap);
    cfg_wdata <= cap;
    cfg_wen   <= 1'b1;
    @(posedge clk);
    cfg_wen   <= 1'b0;
  endtask

  // One random request. The mix leans toward appends and inserts while the
  // list is growing and toward deletes while it is shrinking; values come
  // often from a small pool so that finds hit and duplicates occur.
  task automatic send_random_word();
    logic [FUNC_W-1:0]  fn;
    logic [POS_W-1:0]   pos;
    logic [VALUE_W-1:0] val;
    int unsigned        roll;
    int unsigned        reach;
    roll = $urandom_range(0, 99);
    if (growing) begin
      if (roll < 25) fn = FN_APPEND;
      else if (roll < 50) fn = FN_INSERT;
      else if (roll < 60) fn = FN_EDIT;
      else if (roll < 68) fn = FN_DELETE;
      else if (roll < 82) fn = FN_READ;
      else if (roll < 97) fn = FN_FIND;
      else fn = (roll[0]) ? FN_SPARE_HI : FN_SPARE_LO;
    end else begin
      if (roll < 5) fn = FN_APPEND;
      else if (roll < 10) fn = FN_INSERT;
      else if (roll < 20) fn = FN_EDIT;
      else if (roll < 70) fn = FN_DELETE;
      else if (roll < 82) fn = FN_READ;
      else if (roll < 97) fn = FN_FIND;
      else fn = (roll[0]) ? FN_SPARE_HI : FN_SPARE_LO;
    end
    if ($urandom_range(0, 99) < 80) begin
      reach = $urandom_range(0, seen_count);
      pos   = (reach > 63) ? 6'd63 : reach[POS_W-1:0];
    end else begin
      pos = POS_W'($urandom_range(0, 63));
    end
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      val = $urandom_range(0, 7);
    end else if (roll < 50) begin
      case ($urandom_range(0, 3))
        0:       val = 32'h8000_0000;
        1:       val = 32'h7FFF_FFFF;
        2:       val = 32'hFFFF_FFFF;
        default: val = 32'h0000_0000;
      endcase
    end else begin
      val = $urandom;
    end
    send_word(fn, pos, val);
  endtask

  initial begin
    logic [CFG_W-1:0] phase_caps [6];
    int               phase;
    int               n;

    // Capacities per random phase: above the depth, small, full depth, one,
    // full depth again without idling, and one picked at random.
    phase_caps[0] = 7'd127;
    phase_caps[1] = 7'd5;
    phase_caps[2] = 7'd64;
    phase_caps[3] = 7'd1;
    phase_caps[4] = 7'd64;
    phase_caps[5] = CFG_W'($urandom_range(2, 64));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening at the reset capacity. Requests on the empty list come
    // first: a delete must report empty even with an invalid position.
    send_word(FN_READ,   6'd0,  32'h0000_0001);
    send_word(FN_DELETE, 6'd63, 32'h0000_0000);
    send_word(FN_FIND,   6'd0,  32'h0000_0000);
    send_word(FN_EDIT,   6'd0,  32'h1234_5678);
    send_word(FN_INSERT, 6'd1,  32'h0000_0005);
    // Insert at a position equal to the count behaves as an append.
    send_word(FN_INSERT, 6'd0,  32'h7FFF_FFFF);
    send_word(FN_APPEND, 6'd0,  32'h8000_0000);
    send_word(FN_APPEND, 6'd63, 32'hFFFF_FFFF);
    send_word(FN_INSERT, 6'd1,  32'h0000_0000);
    send_word(FN_INSERT, 6'd4,  32'h5555_5555);
    send_word(FN_EDIT,   6'd2,  32'hAAAA_AAAA);
    send_word(FN_EDIT,   6'd63, 32'h0000_0001);
    send_word(FN_READ,   6'd4,  32'h0000_0000);
    send_word(FN_READ,   6'd5,  32'h0000_0000);
    send_word(FN_FIND,   6'd0,  32'hAAAA_AAAA);
    send_word(FN_FIND,   6'd0,  32'h1234_5678);
    send_word(FN_DELETE, 6'd0,  32'h0000_0000);
    send_word(FN_DELETE, 6'd4,  32'h0000_0000);
    send_word(FN_SPARE_LO, 6'd0,  32'h0000_0000);
    send_word(FN_SPARE_HI, 6'd63, 32'hFFFF_FFFF);
    send_word(FN_READ,   6'd63, 32'h0000_0000);

    // A capacity of zero acts as one, which is now below the count: the
    // entries stay, appends and inserts are refused as full (full is checked
    // ahead of the bad position), and the flag stays set after one delete.
    settle_list();
    write_capacity(7'd0);
    send_word(FN_APPEND, 6'd0,  32'h0000_0003);
    send_word(FN_INSERT, 6'd63, 32'h0000_0003);
    send_word(FN_READ,   6'd3,  32'h0000_0000);
    send_word(FN_DELETE, 6'd3,  32'h0000_0000);

    // Random phases. The first two let the receiver idle more than the
    // sender, the next two the other way round, and the last two run with no
    // idling at all. Two phases also include a long receiver hold-off.
    for (phase = 0; phase < 6; phase++) begin
      settle_list();
      if (phase < 2) begin
        send_idle_pct = 24;
        recv_idle_pct = 56;
      end else if (phase < 4) begin
        send_idle_pct = 56;
        recv_idle_pct = 24;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_capacity(phase_caps[phase]);
      for (n = 0; n < PHASE_WORDS; n++) begin
        if (n == 60 && (phase == 0 || phase == 4)) hold_requests++;
        send_random_word();
      end
    end

    // Let every outstanding result drain, then allow the longest shift or
    // find time for anything stray to show up before the verdict.
    settle_list();
    repeat (80) @(posedge clk);
    if (mismatch_count == 0 && pending_words == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ ordered_array_list_engine_top.f @@
+incdir+rtl/core
rtl/core/oale_pkg.sv
rtl/core/oale_ctrl.sv
rtl/core/oale_dp.sv
rtl/core/ordered_array_list_engine_top.sv
rtl/core/oale_checker.sv
test/oale_result_checker.sv
test/ordered_array_list_engine_top_test.sv
